/* rtl/keypad_consumer_action_mapper_core_macros.svh */
// Assertion macros shared by the keypad action mapper RTL.
`ifndef KEYPAD_CONSUMER_ACTION_MAPPER_CORE_MACROS_SVH
`define KEYPAD_CONSUMER_ACTION_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define KCAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KCAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kcam_pkg.sv */
// Types, constants and helpers shared by the keypad action mapper.
package kcam_pkg;

    localparam int CODE_W    = 16;
    localparam int KEY_W     = 8;
    localparam int KEY_IDX_W = 3;
    localparam int ROT_W     = 6;
    localparam int MAG_W     = 6;
    localparam int CFG_DW    = 64;
    localparam int ADDR_W    = 6;

    // Register index, taken from paddr[5:3].
    typedef enum logic [2:0] {
        REG_KEY_LO  = 3'd0,
        REG_KEY_HI  = 3'd1,
        REG_NONE    = 3'd2,
        REG_VOL_UP  = 3'd3,
        REG_VOL_DN  = 3'd4,
        REG_MUTE    = 3'd5
    } t_reg_idx;

    // Source of the result issued this cycle.
    typedef enum logic [1:0] {
        SRC_KEY  = 2'd0,
        SRC_STEP = 2'd1,
        SRC_MUTE = 2'd2
    } t_src;

    typedef struct packed {
        logic [CFG_DW-1:0] key_lo;
        logic [CFG_DW-1:0] key_hi;
        logic [CODE_W-1:0] none_code;
        logic [CODE_W-1:0] vol_up;
        logic [CODE_W-1:0] vol_dn;
        logic [CODE_W-1:0] mute;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic fire;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic has_key;
        logic has_step;
        logic has_mute;
        logic out_free;
    } t_sts;

    // Action code of key k from the two packed tables.
    function automatic logic [CODE_W-1:0] key_code(input logic [CFG_DW-1:0] lo,
                                                   input logic [CFG_DW-1:0] hi,
                                                   input logic [KEY_IDX_W-1:0] k);
        logic [2*CFG_DW-1:0] tbl;
        tbl = {hi, lo};
        return tbl[{k, 4'b0000} +: CODE_W];
    endfunction

endpackage

/* rtl/kcam_ifs.sv */
// Valid/ready channel interfaces: keypad report in, action item out.
interface kcam_in_if;
    logic                           valid;
    logic                           ready;
    logic [kcam_pkg::KEY_W-1:0]     key_bits;
    logic signed [kcam_pkg::ROT_W-1:0] rotation;
    logic                           button_level;

    modport source (output valid, key_bits, rotation, button_level, input ready);
    modport sink   (input valid, key_bits, rotation, button_level, output ready);
endinterface

interface kcam_out_if;
    logic                           valid;
    logic                           ready;
    logic [kcam_pkg::CODE_W-1:0]    action_code;
    logic                           final_res;

    modport source (output valid, action_code, final_res, input ready);
    modport sink   (input valid, action_code, final_res, output ready);
endinterface

/* rtl/kcam_regs.sv */
// APB configuration register file of the keypad action mapper.
module kcam_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcam_pkg::ADDR_W-1:0]   paddr,
    input  logic [kcam_pkg::CFG_DW-1:0]   pwdata,
    output logic [kcam_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output kcam_pkg::t_cfg                o_cfg
);
    import kcam_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_KEY_LO: n_cfg.key_lo    = pwdata;
                REG_KEY_HI: n_cfg.key_hi    = pwdata;
                REG_NONE:   n_cfg.none_code = pwdata[CODE_W-1:0];
                REG_VOL_UP: n_cfg.vol_up    = pwdata[CODE_W-1:0];
                REG_VOL_DN: n_cfg.vol_dn    = pwdata[CODE_W-1:0];
                REG_MUTE:   n_cfg.mute      = pwdata[CODE_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_KEY_LO: prdata = r_cfg.key_lo;
            REG_KEY_HI: prdata = r_cfg.key_hi;
            REG_NONE:   prdata = CFG_DW'(r_cfg.none_code);
            REG_VOL_UP: prdata = CFG_DW'(r_cfg.vol_up);
            REG_VOL_DN: prdata = CFG_DW'(r_cfg.vol_dn);
            REG_MUTE:   prdata = CFG_DW'(r_cfg.mute);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* rtl/kcam_dp.sv */
// Datapath: report capture, pending work registers, result select, output register.
`include "keypad_consumer_action_mapper_core_macros.svh"
module kcam_dp #(
    parameter int KEYS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kcam_pkg::t_cmd                i_cmd,
    output kcam_pkg::t_sts                o_sts,
    input  kcam_pkg::t_cfg                i_cfg,
    input  logic [kcam_pkg::KEY_W-1:0]    i_key_bits,
    input  logic [kcam_pkg::ROT_W-1:0]    i_rotation,
    input  logic                          i_button_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [kcam_pkg::CODE_W-1:0]   o_action_code,
    output logic                          o_final_res
);
    import kcam_pkg::*;

    logic [KEYS-1:0]      r_prior_keys;
    logic                 r_prior_btn;
    logic [KEYS-1:0]      r_emit;
    logic [MAG_W-1:0]     r_steps;
    logic                 r_vdown;
    logic                 r_mute;
    logic                 r_out_valid;
    logic [CODE_W-1:0]    r_code;
    logic                 r_final;

    logic [KEYS-1:0]      keys;
    logic [KEYS-1:0]      live;
    logic [KEYS-1:0]      rem;
    logic [KEY_IDX_W-1:0] idx;
    logic [MAG_W-1:0]     mag;
    logic [CODE_W-1:0]    n_code;
    logic                 n_final;

    assign keys = i_key_bits[KEYS-1:0];
    // two's complement magnitude; -32 comes out as 6'b100000
    assign mag  = i_rotation[ROT_W-1] ? MAG_W'(~i_rotation + 1'b1) : MAG_W'(i_rotation);
    assign rem  = r_emit & (r_emit - KEYS'(1));

    // keys that map to a real action
    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            live[k] = key_code(i_cfg.key_lo, i_cfg.key_hi, KEY_IDX_W'(k)) != i_cfg.none_code;
        end
    end

    // lowest pending key
    always_comb begin
        idx = '0;
        for (int k = KEYS - 1; k >= 0; k--) begin
            if (r_emit[k]) begin
                idx = KEY_IDX_W'(k);
            end
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_KEY: begin
                n_code  = key_code(i_cfg.key_lo, i_cfg.key_hi, idx);
                n_final = (rem == '0) && (r_steps == '0) && !r_mute;
            end
            SRC_STEP: begin
                n_code  = r_vdown ? i_cfg.vol_dn : i_cfg.vol_up;
                n_final = (r_steps == MAG_W'(1)) && !r_mute;
            end
            default: begin
                n_code  = i_cfg.mute;
                n_final = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_keys <= '0;
            r_prior_btn  <= 1'b0;
            r_emit       <= '0;
            r_steps      <= '0;
            r_vdown      <= 1'b0;
            r_mute       <= 1'b0;
        end else if (i_cmd.load) begin
            r_emit       <= keys & ~r_prior_keys & live;
            r_steps      <= mag;
            r_vdown      <= i_rotation[ROT_W-1];
            r_mute       <= i_button_level & ~r_prior_btn;
            r_prior_keys <= keys;
            r_prior_btn  <= i_button_level;
        end else if (i_cmd.fire) begin
            case (i_cmd.src)
                SRC_KEY:  r_emit  <= rem;
                SRC_STEP: r_steps <= r_steps - MAG_W'(1);
                default:  r_mute  <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_code  <= n_code;
            r_final <= n_final;
        end
    end

    assign o_sts.has_key  = |r_emit;
    assign o_sts.has_step = |r_steps;
    assign o_sts.has_mute = r_mute;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_action_code = r_code;
    assign o_final_res   = r_final;

    `KCAM_ASSERT_NOW(a_fire_slot_free, i_clk, i_rst_n, i_cmd.fire,
        !r_out_valid || i_out_ready, "result issued over an unread one")
    `KCAM_ASSERT_NEXT(a_prior_keys, i_clk, i_rst_n, i_cmd.load,
        r_prior_keys == $past(keys), "prior key bits not captured")
    `KCAM_ASSERT_NEXT(a_final_drains, i_clk, i_rst_n, i_cmd.fire && n_final,
        (r_emit == '0) && (r_steps == '0) && !r_mute, "work left after final item")

endmodule

/* rtl/kcam_ctrl.sv */
// Controller: accepts one report, then issues its results one per cycle while the output register is free.
`include "keypad_consumer_action_mapper_core_macros.svh"
module kcam_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kcam_pkg::t_sts i_sts,
    output kcam_pkg::t_cmd o_cmd
);
    import kcam_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   pending;

    assign pending = i_sts.has_key || i_sts.has_step || i_sts.has_mute;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{load: 1'b0, fire: 1'b0, src: SRC_KEY};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!pending) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.fire = i_sts.out_free;
                    if (i_sts.has_key) begin
                        o_cmd.src = SRC_KEY;
                    end else if (i_sts.has_step) begin
                        o_cmd.src = SRC_STEP;
                    end else begin
                        o_cmd.src = SRC_MUTE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `KCAM_ASSERT_NOW(a_load_when_drained, i_clk, i_rst_n, o_cmd.load,
        !pending, "report taken while results still pending")

endmodule

/* rtl/keypad_consumer_action_mapper_core.sv */
// Top level of the keypad consumer action mapper.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ----------------------------------------
//  i_rep    in   valid/ready        key_bits[7:0], rotation[5:0] s, button_level
//  o_act    out  valid/ready        action_code[15:0], final_res
//  cfg      in   APB psel/penable   paddr[5:0] (8*index), pwdata/prdata 64b
//
// A report is taken, then its results leave at one per cycle while the
// output is not stalled, through a single output register: at most 8 keys,
// 32 encoder steps and a mute per report. The output register sets the pace.
// Output stalls hold the issue loop; the next report is taken once the
// previous one has issued its last item, even while that item waits.
// Reset (synchronous, active low) clears registers, prior keys and button.
module keypad_consumer_action_mapper_core #(
    parameter int KEYS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    kcam_in_if.sink                      i_rep,
    kcam_out_if.source                   o_act,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kcam_pkg::ADDR_W-1:0]  paddr,
    input  logic [kcam_pkg::CFG_DW-1:0]  pwdata,
    output logic [kcam_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import kcam_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    logic [CODE_W-1:0] out_code;
    logic out_final;

    kcam_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: idle / issuing
    kcam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rep.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // edge detect, pending key mask, step count, output register
    kcam_dp #(
        .KEYS (KEYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg          (cfg),
        .i_key_bits     (i_rep.key_bits),
        .i_rotation     (i_rep.rotation),
        .i_button_level (i_rep.button_level),
        .o_out_valid    (out_valid),
        .i_out_ready    (o_act.ready),
        .o_action_code  (out_code),
        .o_final_res    (out_final)
    );

    assign i_rep.ready       = in_ready;
    assign o_act.valid       = out_valid;
    assign o_act.action_code = out_code;
    assign o_act.final_res   = out_final;

endmodule

/* tb/tb_keypad_consumer_action_mapper_core.sv */
// Self-checking testbench for the keypad consumer action mapper core.
`timescale 1ns / 100ps

module tb_keypad_consumer_action_mapper_core;
    import kcam_pkg::*;

    localparam int KEYS = 8;

    // Register slots past the last real register; writes there must be dropped.
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // Extra cycles after the last expected item before touching the registers
    // or ending the run. A report that causes no item is still loaded and
    // passes through the issue state inside the block.
    localparam int DRAIN_CYCLES = 50;

    // One keypad report as queued for the driver.
    typedef struct packed {
        logic [KEY_W-1:0]        keys;
        logic signed [ROT_W-1:0] rot;
        logic                    btn;
    } report_t;

    // One predicted action item.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } action_t;

    logic i_clk;
    logic i_rst_n;

    // Configuration port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    kcam_in_if  rep_if ();
    kcam_out_if act_if ();

    keypad_consumer_action_mapper_core #(
        .KEYS (KEYS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rep   (rep_if),
        .o_act   (act_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Reports waiting to be driven, and actions the mapper still owes us.
    report_t queued_reports[$];
    action_t expected_actions[$];

    // Shadow copy of the register file, updated as each write lands.
    logic [CFG_DW-1:0] map_lo     = '0;
    logic [CFG_DW-1:0] map_hi     = '0;
    logic [CODE_W-1:0] none_code  = '0;
    logic [CODE_W-1:0] up_code    = '0;
    logic [CODE_W-1:0] down_code  = '0;
    logic [CODE_W-1:0] mute_code  = '0;

    // Shadow of the mapper's memory of the previous report.
    logic [KEY_W-1:0] prev_keys   = '0;
    logic             prev_button = 1'b0;

    // Percent chance per cycle that the sender idles / the receiver stalls.
    int idle_pct  = 8;
    int stall_pct = 8;

    int      error_count = 0;
    report_t next_report;
    action_t want_action;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Every input known from time zero.
    initial begin
        rep_if.valid        = 1'b0;
        rep_if.key_bits     = '0;
        rep_if.rotation     = '0;
        rep_if.button_level = 1'b0;
        act_if.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
    end

    // ------------------------------------------------------------------
    // Action predictor: turns one accepted report into the action items it
    // must cause, in order: fresh key presses (ascending, skipping keys
    // mapped to the none code), one volume code per detent, then mute on a
    // button press edge. The last item of the report carries the last flag.
    // ------------------------------------------------------------------
    function automatic void map_report(input logic [KEY_W-1:0] keys_in,
                                       input logic signed [ROT_W-1:0] rot,
                                       input logic btn);
        logic [KEY_W-1:0]  key_mask;
        logic [KEY_W-1:0]  keys;
        logic [KEY_W-1:0]  fresh;
        logic [CFG_DW-1:0] word;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] step_code;
        logic [CODE_W-1:0] codes[$];
        int                steps;
        action_t           act;

        key_mask = KEY_W'((1 << KEYS) - 1);
        keys     = keys_in & key_mask;
        fresh    = keys & ~prev_keys;

        for (int k = 0; k < KEYS; k++) begin
            if (fresh[k]) begin
                word = (k < 4) ? map_lo : map_hi;
                code = word[(k % 4) * CODE_W +: CODE_W];
                if (code != none_code) begin
                    codes.push_back(code);
                end
            end
        end

        // Volume codes go out even when they equal the none code.
        if (rot < 0) begin
            steps     = -int'(rot);
            step_code = down_code;
        end else begin
            steps     = int'(rot);
            step_code = up_code;
        end
        for (int s = 0; s < steps; s++) begin
            codes.push_back(step_code);
        end

        if (!prev_button && btn) begin
            codes.push_back(mute_code);
        end

        for (int i = 0; i < codes.size(); i++) begin
            act.code = codes[i];
            act.last = (i == codes.size() - 1);
            expected_actions.push_back(act);
        end

        prev_keys   = keys;
        prev_button = btn;
    endfunction

    // ------------------------------------------------------------------
    // Report driver: holds an item until it is taken, predicts on accept,
    // then either presents the next queued report or idles.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rep_if.valid <= 1'b0;
        end else begin
            if (rep_if.valid && rep_if.ready) begin
                map_report(rep_if.key_bits, rep_if.rotation, rep_if.button_level);
            end
            if (!rep_if.valid || rep_if.ready) begin
                if (queued_reports.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_report          = queued_reports.pop_front();
                    rep_if.valid        <= 1'b1;
                    rep_if.key_bits     <= next_report.keys;
                    rep_if.rotation     <= next_report.rot;
                    rep_if.button_level <= next_report.btn;
                end else begin
                    rep_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            act_if.ready <= 1'b0;
        end else begin
            act_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Action monitor: every taken item is checked against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && act_if.valid && act_if.ready) begin
            if (expected_actions.size() == 0) begin
                $display("%0t: unexpected action item: code %h last %b",
                         $time, act_if.action_code, act_if.final_res);
                error_count++;
            end else begin
                want_action = expected_actions.pop_front();
                if (act_if.action_code !== want_action.code) begin
                    $display("%0t: action_code mismatch: expected %h, actual %h",
                             $time, want_action.code, act_if.action_code);
                    error_count++;
                end
                if (act_if.final_res !== want_action.last) begin
                    $display("%0t: final_res mismatch: expected %b, actual %b",
                             $time, want_action.last, act_if.final_res);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // APB write; the shadow takes the value as the access cycle ends.
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_LO: map_lo    = val;
            REG_KEY_HI: map_hi    = val;
            REG_NONE:   none_code = val[CODE_W-1:0];
            REG_VOL_UP: up_code   = val[CODE_W-1:0];
            REG_VOL_DN: down_code = val[CODE_W-1:0];
            REG_MUTE:   mute_code = val[CODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_report(input logic [KEY_W-1:0] keys,
                               input logic signed [ROT_W-1:0] rot,
                               input logic btn);
        report_t r;
        r.keys = keys;
        r.rot  = rot;
        r.btn  = btn;
        queued_reports.push_back(r);
    endtask

    // Wait until the sender is empty and every predicted item has come back,
    // then give a no-item report time to finish inside the block.
    task automatic wait_drained();
        while (queued_reports.size() != 0 || rep_if.valid || expected_actions.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random register set. The none code is copied from one of the key slots
    // so that some keys fall silent; narrow registers get junk in the upper
    // bits, which must be dropped.
    task automatic random_settings();
        logic [CFG_DW-1:0] lo;
        logic [CFG_DW-1:0] hi;
        logic [CODE_W-1:0] silent;
        logic [CODE_W-1:0] up;
        int                k;

        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        k  = $urandom_range(KEYS - 1);
        silent = (k < 4) ? lo[(k % 4) * CODE_W +: CODE_W] : hi[(k % 4) * CODE_W +: CODE_W];
        up = ($urandom_range(3) == 0) ? silent : CODE_W'($urandom);
        write_reg(REG_KEY_LO, lo);
        write_reg(REG_KEY_HI, hi);
        write_reg(REG_NONE,   {$urandom, 16'($urandom), silent});
        write_reg(REG_VOL_UP, {$urandom, 16'($urandom), up});
        write_reg(REG_VOL_DN, {$urandom, $urandom});
        write_reg(REG_MUTE,   {$urandom, $urandom});
    endtask

    // Random reports: key maps that press, add to and release keys, mostly
    // small encoder moves with an occasional move drawn from the full range.
    task automatic random_reports(input int count);
        logic [KEY_W-1:0]        keys;
        logic signed [ROT_W-1:0] rot;

        keys = '0;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: keys = '0;
                1: keys = keys | KEY_W'(1 << $urandom_range(KEY_W - 1));
                default: keys = KEY_W'($urandom);
            endcase
            if ($urandom_range(3) == 0) begin
                rot = ROT_W'($urandom);
            end else begin
                rot = ROT_W'(int'($urandom_range(4)) - 2);
            end
            push_report(keys, rot, 1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence. Registers change only at phase boundaries, after the
    // sender has stopped and all owed items have arrived; each of these
    // boundaries is also a full pause of the sender.
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);

        // Reset values: every code is zero, so all keys equal the none code
        // and stay silent, while volume and mute codes (also zero) still go out.
        push_report(8'hFF, 6'sd0, 1'b1);
        push_report(8'h00, 6'sd31, 1'b0);
        push_report(8'h00, -6'sd32, 1'b0);
        wait_drained();

        // Distinct codes, keys 2 and 5 mapped to the none code.
        write_reg(REG_KEY_LO, 64'h1104_0A0A_1102_1101);
        write_reg(REG_KEY_HI, 64'h1108_1107_0A0A_1105);
        write_reg(REG_NONE,   64'hDEAD_BEEF_0000_0A0A);
        write_reg(REG_VOL_UP, 64'h0000_0000_0000_00E9);
        write_reg(REG_VOL_DN, 64'h0000_0000_0000_00EA);
        write_reg(REG_MUTE,   64'hFFFF_FFFF_FFFF_00E2);
        push_report(8'h00, 6'sd0, 1'b0);    // nothing happens
        push_report(8'hFF, 6'sd0, 1'b0);    // six keys, two silent
        push_report(8'hFF, 6'sd1, 1'b1);    // held keys, one step up, mute edge
        push_report(8'hFF, -6'sd1, 1'b1);   // button held: no second mute
        push_report(8'h55, 6'sd0, 1'b0);    // only releases
        push_report(8'hAA, 6'sd0, 1'b0);    // fresh odd keys, key 5 silent
        push_report(8'h01, 6'sd31, 1'b0);   // key 0 then full positive spin
        push_report(8'h80, -6'sd32, 1'b1);  // key 7, full negative spin, mute
        wait_drained();

        // All ones everywhere: every key is silent, volume and mute codes
        // equal the none code but are still sent. Spare slots must do nothing.
        write_reg(REG_KEY_LO,  '1);
        write_reg(REG_KEY_HI,  '1);
        write_reg(REG_NONE,    '1);
        write_reg(REG_VOL_UP,  '1);
        write_reg(REG_VOL_DN,  '1);
        write_reg(REG_MUTE,    '1);
        write_reg(REG_SPARE_6, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_SPARE_7, '1);
        push_report(8'h00, 6'sd0, 1'b0);
        push_report(8'hFF, 6'sd0, 1'b0);
        push_report(8'h00, 6'sd31, 1'b1);
        push_report(8'h00, -6'sd32, 1'b0);
        wait_drained();

        // All-ones key codes against a zero none code, zero volume and mute.
        write_reg(REG_NONE,   '0);
        write_reg(REG_VOL_UP, '0);
        write_reg(REG_VOL_DN, '0);
        write_reg(REG_MUTE,   '0);
        push_report(8'hFF, 6'sd2, 1'b1);
        push_report(8'h0F, -6'sd2, 1'b0);
        push_report(8'hF0, 6'sd0, 1'b1);
        wait_drained();

        // Random phases, one of them with no idling or stalls at all.
        for (int phase = 0; phase < 5; phase++) begin
            random_settings();
            if (phase == 2) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = 8;
                stall_pct = 8;
            end
            random_reports(54);
            wait_drained();
        end

        if (expected_actions.size() != 0) begin
            $display("%0t: %0d expected action items never arrived",
                     $time, expected_actions.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
